// ===== rtl/wmpe_pkg.sv =====
// Shared widths, register codes, the event job type and a priority helper
// for the windowed presence event block. No dependencies.
package wmpe_pkg;

    localparam int LEVEL_W = 6;
    localparam int TIME_W  = 32;
    localparam int WIN_W   = 16;
    localparam int CH_W    = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index codes (byte address divided by four).
    localparam logic [PADDR_W-3:0] REG_WINDOW_MS = '0;

    localparam logic [WIN_W-1:0] WIN_RESET = 16'd5;

    // One window close handed from the front end to the event sequencer.
    typedef struct packed {
        logic               load;
        logic [LEVEL_W-1:0] mask;
        logic [LEVEL_W-1:0] rise;
        logic [TIME_W-1:0]  now;
        logic [LEVEL_W-1:0] pmask;
    } t_job;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [CH_W-1:0] lowest_set(input logic [LEVEL_W-1:0] m);
        logic [CH_W-1:0] idx;
        idx = '0;
        for (int i = LEVEL_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = CH_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/wmpe_if.sv =====
// Valid/ready channel interfaces for line samples and presence events.
// Depends on wmpe_pkg for field widths.
interface wmpe_in_if;
    import wmpe_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] line_levels;
    logic [TIME_W-1:0]  time_ms;

    modport source (output valid, output line_levels, output time_ms, input ready);
    modport sink   (input valid, input line_levels, input time_ms, output ready);
endinterface

interface wmpe_out_if;
    import wmpe_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    channel;
    logic               is_exit;
    logic [TIME_W-1:0]  held_ms;
    logic [LEVEL_W-1:0] presence_mask;
    logic               last;

    modport source (output valid, output channel, output is_exit, output held_ms,
                    output presence_mask, output last, input ready);
    modport sink   (input valid, input channel, input is_exit, input held_ms,
                    input presence_mask, input last, output ready);
endinterface

// ===== rtl/wmpe_evt_seq.sv =====
// Event sequencer: walks the changed lines of one window close in channel
// order, keeping entry times in a small synchronous memory.
// Depends on wmpe_pkg and wmpe_out_if.
module wmpe_evt_seq #(
    parameter int NUM_LINES = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wmpe_pkg::t_job    i_job,
    output logic              o_busy,
    wmpe_out_if.source        o_out
);
    import wmpe_pkg::*;

    localparam int ACT_LINES = (NUM_LINES < LEVEL_W) ? NUM_LINES : LEVEL_W;
    localparam int IDX_W     = (ACT_LINES > 1) ? $clog2(ACT_LINES) : 1;

    // Pending job.
    logic [LEVEL_W-1:0] r_mask;
    logic [LEVEL_W-1:0] r_rise;
    logic [TIME_W-1:0]  r_now;
    logic [LEVEL_W-1:0] r_pmask;

    // Output register.
    logic               r_ov;
    logic [CH_W-1:0]    r_ch;
    logic               r_ex;
    logic               r_last;
    logic [LEVEL_W-1:0] r_opmask;
    logic [TIME_W-1:0]  r_onow;

    // Entry-time memory with per-entry valid bits.
    logic [TIME_W-1:0]    mem_entry [ACT_LINES];
    logic [ACT_LINES-1:0] r_ent_vld;
    logic [TIME_W-1:0]    r_rdata;
    logic                 r_rvld;

    logic               w_issue;
    logic [CH_W-1:0]    w_idx;
    logic [IDX_W-1:0]   w_addr;
    logic [LEVEL_W-1:0] w_rem;
    logic [TIME_W-1:0]  w_start;

    // Pick the lowest pending line and issue it once the output can take it.
    assign w_idx   = lowest_set(r_mask);
    assign w_addr  = w_idx[IDX_W-1:0];
    assign w_rem   = r_mask & (r_mask - LEVEL_W'(1));
    assign w_issue = (r_mask != '0) && (!r_ov || o_out.ready);
    assign o_busy  = (r_mask != '0);

    // Job control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_job.load) begin
            r_mask <= i_job.mask;
        end else if (w_issue) begin
            r_mask <= w_rem;
        end
    end

    // Job payload.
    always_ff @(posedge i_clk) begin
        if (i_job.load) begin
            r_rise  <= i_job.rise;
            r_now   <= i_job.now;
            r_pmask <= i_job.pmask;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_issue) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_ch     <= w_idx;
            r_ex     <= !r_rise[w_idx];
            r_last   <= (w_rem == '0);
            r_opmask <= r_pmask;
            r_onow   <= r_now;
        end
    end

    // Entry lines record the time; exit lines read it back into a register that holds it beside the output event.
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            if (r_rise[w_idx]) begin
                mem_entry[w_addr] <= r_now;
            end else begin
                r_rdata <= mem_entry[w_addr];
                r_rvld  <= r_ent_vld[w_addr];
            end
        end
    end

    // Entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (w_issue && r_rise[w_idx]) begin
            r_ent_vld[w_addr] <= 1'b1;
        end
    end

    assign w_start = r_rvld ? r_rdata : '0;

    assign o_out.valid         = r_ov;
    assign o_out.channel       = r_ch;
    assign o_out.is_exit       = r_ex;
    assign o_out.held_ms       = r_ex ? (r_onow - w_start) : '0;
    assign o_out.presence_mask = r_opmask;
    assign o_out.last          = r_last;

endmodule

// ===== rtl/windowed_multi_input_presence_events.sv =====
// Windowed presence detector: top level with window timing, seen latches,
// presence state and the APB register. Depends on wmpe_pkg, wmpe_if and
// wmpe_evt_seq.
//
// A line sample is taken every cycle while no events are pending. A sample
// that closes a window with k lines changing presence produces k events, one
// per cycle while the event sink takes them, in channel order; each event
// takes one access of the single entry-time memory port, so input is held
// off after such a sample until the sequencer has issued all k events, which
// takes longer while the sink stalls. A close with no changes costs nothing
// extra. Events for exits carry the time since the line's entry, modulo 2^32.
module windowed_multi_input_presence_events #(
    parameter int NUM_LINES = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wmpe_in_if.sink                       i_in,
    wmpe_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wmpe_pkg::PADDR_W-1:0]  paddr,
    input  logic [wmpe_pkg::PDATA_W-1:0]  pwdata,
    output logic [wmpe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import wmpe_pkg::*;

    localparam int ACT_LINES = (NUM_LINES < LEVEL_W) ? NUM_LINES : LEVEL_W;
    localparam logic [LEVEL_W-1:0] LINE_MASK =
        LEVEL_W'((32'd1 << ACT_LINES) - 32'd1);

    logic [WIN_W-1:0]   r_win;
    logic [LEVEL_W-1:0] r_seen;
    logic [LEVEL_W-1:0] r_presence;
    logic [TIME_W-1:0]  r_wstart;

    logic               w_acc;
    logic               w_busy;
    logic [LEVEL_W-1:0] w_seen;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_close;
    logic               w_wr;
    logic [PADDR_W-3:0] w_reg;
    t_job               w_job;

    // Configuration register access.
    assign w_reg  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && (w_reg == REG_WINDOW_MS);
    assign pready = 1'b1;
    assign prdata = (w_reg == REG_WINDOW_MS) ? PDATA_W'(r_win) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_RESET;
        end else if (w_wr) begin
            r_win <= pwdata[WIN_W-1:0];
        end
    end

    // Sample acceptance and window close decision.
    assign i_in.ready = !w_busy;
    assign w_acc      = i_in.valid && !w_busy;
    assign w_seen     = (r_seen | i_in.line_levels) & LINE_MASK;
    assign w_elapsed  = i_in.time_ms - r_wstart;
    assign w_close    = (w_elapsed >= TIME_W'(r_win));

    // Hand the changed lines of a close to the sequencer.
    always_comb begin
        w_job.load  = w_acc && w_close;
        w_job.mask  = r_presence ^ w_seen;
        w_job.rise  = w_seen & ~r_presence;
        w_job.now   = i_in.time_ms;
        w_job.pmask = w_seen;
    end

    // Latches, presence and window start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_presence <= '0;
            r_wstart   <= '0;
        end else if (w_acc) begin
            if (w_close) begin
                r_seen     <= '0;
                r_presence <= w_seen;
                r_wstart   <= i_in.time_ms;
            end else begin
                r_seen <= w_seen;
            end
        end
    end

    wmpe_evt_seq #(
        .NUM_LINES (NUM_LINES)
    ) u_evt_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_job),
        .o_busy  (w_busy),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    // An event's presence bit agrees with its kind.
    a_evt_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.presence_mask[o_out.channel] == !o_out.is_exit))
        else $error("event kind disagrees with presence mask");

    // A close that changes presence leaves work for the sequencer.
    a_job_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_close && (w_job.mask != '0)) |=> w_busy)
        else $error("window close with changes started no events");

    // A close clears the seen latches.
    a_latch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_close) |=> (r_seen == '0))
        else $error("seen latches not cleared on window close");
`endif

endmodule
